// ===== rtl/utf8_sanitize_transcode_top_defines.svh =====
// Assertion macros for the UTF-8 sanitizer / Latin-1 widener.
// Used by utf8_sanitize_transcode_top; expects signals clock and reset in scope.
`ifndef UTF8_SANITIZE_TRANSCODE_TOP_DEFINES_SVH
`define UTF8_SANITIZE_TRANSCODE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define U8ST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define U8ST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/u8st_pkg.sv =====
// Shared types, constants and the lead-byte decoder for the UTF-8 sanitizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8st_pkg;

   // announced sequence length from a lead byte, 0 for a bad lead
   typedef logic [2:0] lead_len_type;

   // one queued item, classified by the front end
   typedef struct packed {
      logic [7:0]   text_byte;
      logic         end_of_text;
      logic         latin;
      lead_len_type lead_len;
   } item_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic       busy;
      logic [2:0] window_count;
   } back_status_type;

   // source encoding register values
   localparam logic ENC_UTF8   = 1'b0;
   localparam logic ENC_LATIN1 = 1'b1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_SOURCE_ENCODING = '0;

   // code point limits
   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [20:0] MAX_CP         = 21'h10FFFF;
   localparam logic [20:0] SURR_LO        = 21'h00D800;
   localparam logic [20:0] SURR_HI        = 21'h00DFFF;
   localparam logic [20:0] MIN_CP2        = 21'h000080;
   localparam logic [20:0] MIN_CP3        = 21'h000800;
   localparam logic [20:0] MIN_CP4        = 21'h010000;

   // U+FFFD as three UTF-8 bytes
   localparam logic [7:0] REPL_BYTE0 = {4'hE, REPLACEMENT_CP[15:12]};
   localparam logic [7:0] REPL_BYTE1 = {2'b10, REPLACEMENT_CP[11:6]};
   localparam logic [7:0] REPL_BYTE2 = {2'b10, REPLACEMENT_CP[5:0]};

   function automatic lead_len_type lead_length(input logic [7:0] b);
      lead_len_type len;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_sanitize_transcode_top.sv =====
// UTF-8 sanitizer and Latin-1 to UTF-8 widener.
//
// req channel: one source byte per item in req_tdata, req_tlast marks the
// last byte of the text and flushes any unfinished sequence.
// rsp channel: one UTF-8 byte per item; rsp_tuser flags bytes of an inserted
// U+FFFD, rsp_tlast marks the last byte caused by one input item, and
// rsp_tdata[8] marks the last byte of the whole text. An input item that only
// opens or extends a sequence still waiting for bytes gives no output.
// csr port: register 0 (source_encoding) at address 0; 0 = UTF-8 sanitize,
// 1 = Latin-1. A write drops any pending partial sequence.
// An accepted item is written into the queue, loaded by the back end and its
// bytes leave through the output register. The back end sends one output byte
// per cycle while rsp_tready allows; an item yields 1 to 12 output bytes (3 for
// a replaced byte), or none.
// A two-entry queue decouples input acceptance from output.
// Reset clears the queue, the pending sequence and source_encoding.
// When rsp_tready is low the output byte holds and input is accepted until
// the queue fills.
`default_nettype none

`include "utf8_sanitize_transcode_top_defines.svh"

module utf8_sanitize_transcode_top (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] text_byte
   input  logic                          req_tlast,   // end_of_text
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // [7:0] utf8_byte, [8] text_done
   output logic                          rsp_tuser,   // is_replacement
   output logic                          rsp_tlast,   // last_of_run
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [u8st_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import u8st_pkg::*;

   logic            enc_ff, enc_in;
   logic            csr_hit, csr_wr_enc;
   logic            queue_ready, push, pop, head_valid;
   item_type        push_item, head_item;
   back_status_type back_status;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_SOURCE_ENCODING);
   assign csr_wr_enc = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign enc_in     = csr_wr_enc ? csr_pwdata[0] : enc_ff;
   assign csr_prdata = csr_hit ? {31'd0, enc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_UTF8;
      end else begin
         enc_ff <= enc_in;
      end
   end

   u8st_front u_front (
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .source_encoding (enc_ff),
      .queue_ready     (queue_ready),
      .push            (push),
      .push_item       (push_item)
   );

   u8st_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .not_full   (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   u8st_back u_back (
      .clock         (clock),
      .reset         (reset),
      .clear_pending (csr_wr_enc),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .status        (back_status)
   );

   // checks
   `U8ST_ASSERT_IMP(a_rep_bytes, rsp_tvalid && rsp_tuser, rsp_tdata[7:0] == REPL_BYTE0 || rsp_tdata[7:0] == REPL_BYTE1 || rsp_tdata[7:0] == REPL_BYTE2, "replacement flag on a non U+FFFD byte")
   `U8ST_ASSERT_IMP(a_done_is_last, rsp_tvalid && rsp_tdata[8], rsp_tlast, "text end without end of run")
   `U8ST_ASSERT_IMP(a_pending_bound, !back_status.busy, back_status.window_count <= 3'd3, "idle with more than three pending bytes")
   `U8ST_ASSERT_NXT(a_cfg_clears, csr_wr_enc, back_status.window_count == 3'd0, "config write left pending bytes")

endmodule

`default_nettype wire

// ===== rtl/u8st_front.sv =====
// Front end: accepts input items and classifies them (mode, lead length).
// Depends on u8st_pkg; feeds u8st_queue.
`default_nettype none

module u8st_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,    // [7:0] text_byte
   input  logic               req_tlast,    // end_of_text
   input  logic               source_encoding,
   input  logic               queue_ready,
   output logic               push,
   output u8st_pkg::item_type push_item
);
   import u8st_pkg::*;

   // take an item whenever the queue has room
   assign req_tready = queue_ready;
   assign push       = req_tvalid && queue_ready;

   // classify the byte at entry
   always_comb begin
      push_item.text_byte   = req_tdata;
      push_item.end_of_text = req_tlast;
      push_item.latin       = (source_encoding == ENC_LATIN1);
      push_item.lead_len    = lead_length(req_tdata);
   end

endmodule

`default_nettype wire

// ===== rtl/u8st_queue.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on u8st_pkg.
`default_nettype none

module u8st_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8st_pkg::item_type push_item,
   output logic               not_full,
   input  logic               pop,
   output logic               head_valid,
   output u8st_pkg::item_type head_item
);
   import u8st_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign not_full   = (count_ff != (PTR_W+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/u8st_back.sv =====
// Back end: scans the byte window, checks sequences and, while rsp_tready allows,
// emits one byte per cycle via a registered output stage. Depends on u8st_pkg.
`default_nettype none

module u8st_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear_pending,
   input  logic                      head_valid,
   input  u8st_pkg::item_type        head_item,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [7:0] utf8_byte, [8] text_done
   output logic                      rsp_tuser,   // is_replacement
   output logic                      rsp_tlast,   // last_of_run
   output u8st_pkg::back_status_type status
);
   import u8st_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   // well-formedness of a 2..4 byte sequence starting at window head
   function automatic logic sequence_ok(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input lead_len_type len);
      logic [20:0] cp;
      logic        ok;
      cp = '0;
      ok = 1'b0;
      case (len)
         3'd2: begin
            cp = {10'd0, b0[4:0], b1[5:0]};
            ok = (b1[7:6] == 2'b10) && (cp >= MIN_CP2);
         end
         3'd3: begin
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (cp >= MIN_CP3) &&
                 !((cp >= SURR_LO) && (cp <= SURR_HI));
         end
         3'd4: begin
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10) &&
                 (cp >= MIN_CP4) && (cp <= MAX_CP);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

   // state and registered outputs
   state_type    state_ff, state_in;
   logic [7:0]   win_byte_ff [4];
   logic [7:0]   win_byte_in [4];
   lead_len_type win_len_ff  [4];
   lead_len_type win_len_in  [4];
   logic [2:0]   cnt_ff, cnt_in;
   logic [1:0]   run_idx_ff, run_idx_in;
   logic         eot_ff, eot_in;
   logic         latin_ff, latin_in;
   logic [7:0]   lat_byte_ff, lat_byte_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;
   logic         rsp_rep_ff, rsp_rep_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_done_ff, rsp_done_in;

   // scan decisions
   logic         running, utf8_run, out_free;
   logic         too_short, wait_more, seq_ok, rep, lat_two;
   logic [2:0]   run_len, advance, rem, base_cnt;
   lead_len_type head_len, next_len;
   logic         more, run_last, emit_now, run_done, step_done, load;
   logic [7:0]   emit_byte;
   logic [7:0]   sh_byte [4];
   lead_len_type sh_len  [4];

   assign running  = (state_ff == ST_RUN);
   assign utf8_run = running && !latin_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // classify the sequence at the window head
   always_comb begin
      head_len  = win_len_ff[0];
      too_short = (head_len > cnt_ff);
      wait_more = utf8_run && too_short && !eot_ff;
      seq_ok    = sequence_ok(win_byte_ff[0], win_byte_ff[1], win_byte_ff[2],
                              win_byte_ff[3], head_len);
      rep       = (head_len == 3'd0) || too_short || ((head_len != 3'd1) && !seq_ok);
      lat_two   = lat_byte_ff[7];
      advance   = rep ? 3'd1 : head_len;
      rem       = cnt_ff - advance;
      if (latin_ff) begin
         run_len = lat_two ? 3'd2 : 3'd1;
      end else begin
         run_len = rep ? 3'd3 : head_len;
      end
      case (advance)
         3'd1:    next_len = win_len_ff[1];
         3'd2:    next_len = win_len_ff[2];
         3'd3:    next_len = win_len_ff[3];
         default: next_len = 3'd0;
      endcase
      // another output byte follows in this item unless the next lead must wait
      more      = !latin_ff && (rem != 3'd0) && !((next_len > rem) && !eot_ff);
      run_last  = ({1'b0, run_idx_ff} == (run_len - 3'd1));
   end

   // byte to emit this cycle
   always_comb begin
      if (latin_ff) begin
         if (run_idx_ff == 2'd0) begin
            emit_byte = lat_two ? {6'b110000, lat_byte_ff[7:6]} : lat_byte_ff;
         end else begin
            emit_byte = {2'b10, lat_byte_ff[5:0]};
         end
      end else if (rep) begin
         case (run_idx_ff)
            2'd0:    emit_byte = REPL_BYTE0;
            2'd1:    emit_byte = REPL_BYTE1;
            default: emit_byte = REPL_BYTE2;
         endcase
      end else begin
         case (run_idx_ff)
            2'd0:    emit_byte = win_byte_ff[0];
            2'd1:    emit_byte = win_byte_ff[1];
            2'd2:    emit_byte = win_byte_ff[2];
            default: emit_byte = win_byte_ff[3];
         endcase
      end
   end

   // window shifted past the finished sequence
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sh_byte[k] = win_byte_ff[k];
         sh_len[k]  = win_len_ff[k];
         for (int a = 1; k + a < 4; a++) begin
            if (advance == 3'(a)) begin
               sh_byte[k] = win_byte_ff[k + a];
               sh_len[k]  = win_len_ff[k + a];
            end
         end
      end
   end

   // sequencing
   always_comb begin
      emit_now  = running && !wait_more && out_free;
      run_done  = emit_now && run_last;
      step_done = (run_done && !more) || wait_more;
      load      = head_valid && (!running || step_done);
      pop       = load;
      base_cnt  = (utf8_run && run_done) ? rem : cnt_ff;

      state_in = state_ff;
      if (load) begin
         state_in = ST_RUN;
      end else if (step_done) begin
         state_in = ST_IDLE;
      end

      run_idx_in = run_idx_ff;
      if (load) begin
         run_idx_in = 2'd0;
      end else if (emit_now) begin
         run_idx_in = run_last ? 2'd0 : run_idx_ff + 2'd1;
      end

      // window update: shift out consumed bytes, append the new byte
      for (int k = 0; k < 4; k++) begin
         win_byte_in[k] = (utf8_run && run_done) ? sh_byte[k] : win_byte_ff[k];
         win_len_in[k]  = (utf8_run && run_done) ? sh_len[k]  : win_len_ff[k];
         if (load && !head_item.latin && (base_cnt == 3'(k))) begin
            win_byte_in[k] = head_item.text_byte;
            win_len_in[k]  = head_item.lead_len;
         end
      end
      cnt_in = base_cnt;
      if (load && !head_item.latin) begin
         cnt_in = base_cnt + 3'd1;
      end
      if (clear_pending) begin
         cnt_in = 3'd0;
      end

      eot_in      = load ? head_item.end_of_text : eot_ff;
      latin_in    = load ? head_item.latin       : latin_ff;
      lat_byte_in = (load && head_item.latin) ? head_item.text_byte : lat_byte_ff;

      // output register
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_rep_in   = rsp_rep_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_rep_in   = !latin_ff && rep;
         rsp_last_in  = run_last && !more;
         rsp_done_in  = run_last && !more && eot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         run_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         run_idx_ff   <= run_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int k = 0; k < 4; k++) begin
         win_byte_ff[k] <= win_byte_in[k];
         win_len_ff[k]  <= win_len_in[k];
      end
      eot_ff      <= eot_in;
      latin_ff    <= latin_in;
      lat_byte_ff <= lat_byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_rep_ff  <= rsp_rep_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_done_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_rep_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.busy         = running || rsp_valid_ff;
   assign status.window_count = cnt_ff;

endmodule

`default_nettype wire

// ===== tb/utf8_sanitize_transcode_top_tb.sv =====
// Self-checking testbench for utf8_sanitize_transcode_top: UTF-8 and Latin-1
// streams with random gaps and stalls, checked against an in-bench predictor.
// Depends on u8st_pkg and the RTL of the block only.
`default_nettype none

module utf8_sanitize_transcode_top_tb;
   import u8st_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;

   // one expected output item
   typedef struct {
      logic [7:0] utf8_byte;
      logic       is_replacement;
      logic       last_of_run;
      logic       text_done;
   } out_byte_type;

   // predicts output bytes per accepted text byte and checks them in order
   class transcode_scoreboard;
      out_byte_type expected_bytes[$];
      out_byte_type step_bytes[$];
      logic [7:0]   held_bytes[3];
      logic [7:0]   scan_buf[4];
      int           held_count;
      logic         encoding;
      int           failures;

      function new();
         held_count = 0;
         encoding   = ENC_UTF8;
         failures   = 0;
      endfunction

      // any register write drops an unfinished sequence
      function void set_encoding(logic enc);
         encoding   = enc;
         held_count = 0;
      endfunction

      function void add_byte(logic [7:0] b, logic rep);
         out_byte_type o;
         o.utf8_byte      = b;
         o.is_replacement = rep;
         o.last_of_run    = 1'b0;
         o.text_done      = 1'b0;
         step_bytes.push_back(o);
      endfunction

      // U+FFFD is EF BF BD
      function void add_fffd();
         add_byte(8'hEF, 1'b1);
         add_byte(8'hBF, 1'b1);
         add_byte(8'hBD, 1'b1);
      endfunction

      // announced length from a lead byte, 0 for a bad lead
      function int seq_len(logic [7:0] b);
         if (b[7] == 1'b0) return 1;
         if (b[7:5] == 3'b110) return 2;
         if (b[7:4] == 4'b1110) return 3;
         if (b[7:3] == 5'b11110) return 4;
         return 0;
      endfunction

      // full sequence at scan_buf[pos], length len (2..4)
      function bit seq_ok(int pos, int len);
         logic [31:0] cp;
         int k;
         case (len)
            2: cp = {27'd0, scan_buf[pos][4:0]};
            3: cp = {28'd0, scan_buf[pos][3:0]};
            default: cp = {29'd0, scan_buf[pos][2:0]};
         endcase
         for (k = 1; k < len; k++) begin
            if (scan_buf[pos + k][7:6] != 2'b10) return 0;
            cp = (cp << 6) | {26'd0, scan_buf[pos + k][5:0]};
         end
         if ((len == 2 && cp < 32'h80) || (len == 3 && cp < 32'h800) ||
             (len == 4 && cp < 32'h10000) || cp > 32'h10FFFF ||
             (cp >= 32'hD800 && cp <= 32'hDFFF)) return 0;
         return 1;
      endfunction

      function void note_text_byte(logic [7:0] b, logic eot);
         int m;
         int i;
         int k;
         int len;
         step_bytes.delete();
         if (encoding == ENC_LATIN1) begin
            if (b[7] == 1'b0) begin
               add_byte(b, 1'b0);
            end else begin
               add_byte({6'b110000, b[7:6]}, 1'b0);
               add_byte({2'b10, b[5:0]}, 1'b0);
            end
         end else begin
            for (k = 0; k < held_count; k++) scan_buf[k] = held_bytes[k];
            scan_buf[held_count] = b;
            m = held_count + 1;
            i = 0;
            while (i < m) begin
               len = seq_len(scan_buf[i]);
               if (len == 0) begin
                  add_fffd();
                  i++;
               end else if (len > m - i) begin
                  // unfinished: wait, unless the text ends here
                  if (!eot) break;
                  add_fffd();
                  i++;
               end else if (len == 1 || seq_ok(i, len)) begin
                  for (k = 0; k < len; k++) add_byte(scan_buf[i + k], 1'b0);
                  i += len;
               end else begin
                  // reject the lead only, rescan what follows
                  add_fffd();
                  i++;
               end
            end
            held_count = m - i;
            for (k = 0; k < held_count; k++) held_bytes[k] = scan_buf[i + k];
         end
         if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size() - 1].last_of_run = 1'b1;
            step_bytes[step_bytes.size() - 1].text_done   = eot;
         end
         foreach (step_bytes[k]) expected_bytes.push_back(step_bytes[k]);
      endfunction

      function void check_out_byte(logic [7:0] b, logic rep, logic last, logic done);
         out_byte_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: output item with nothing expected, utf8_byte %h", $time, b);
            failures++;
            return;
         end
         want = expected_bytes.pop_front();
         if (b !== want.utf8_byte) begin
            $display("%0t: utf8_byte expected %h got %h", $time, want.utf8_byte, b);
            failures++;
         end
         if (rep !== want.is_replacement) begin
            $display("%0t: is_replacement expected %b got %b", $time,
                     want.is_replacement, rep);
            failures++;
         end
         if (last !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last_of_run, last);
            failures++;
         end
         if (done !== want.text_done) begin
            $display("%0t: text_done expected %b got %b", $time, want.text_done, done);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   transcode_scoreboard sb;
   bit         no_idle = 1'b0;
   int         cycle_count = 0;
   logic [7:0] run_bytes[$];

   // directed text: {end_of_text, byte}
   logic [8:0] directed_utf8[$] = '{
      9'h07F,                          // ASCII top
      9'h0C3, 9'h0A9,                  // two-byte
      9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte
      9'h0C0, 9'h080,                  // overlong
      9'h0ED, 9'h0A0, 9'h080,          // surrogate
      9'h0F4, 9'h090, 9'h080, 9'h080,  // above U+10FFFF
      9'h0FF,                          // bad lead
      9'h0E2, 9'h041, 9'h042,          // bad continuation, waits for full length
      9'h0E2, 9'h182,                  // incomplete at end of text
      9'h0F0                           // left pending, dropped by the next write
   };
   logic [8:0] directed_latin[$] = '{9'h0FF, 9'h100};

   utf8_sanitize_transcode_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: check each item, then maybe stall
   initial begin
      int unsigned n;
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_out_byte(rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8]);
            n = no_idle ? 0 : $urandom_range(0, 5);
            if (n != 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic send_text_byte(logic [7:0] b, logic eot);
      int unsigned n;
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      sb.note_text_byte(b, eot);
   endtask

   // stop sending, wait for every expected byte, then for items with no output
   task automatic wait_output_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_source_encoding(logic enc);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_SOURCE_ENCODING, 2'b00};
      csr_pwdata  <= {31'd0, enc};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_encoding(enc);
      // read back the register value
      @(posedge clock);
      if (csr_prdata !== {31'd0, enc}) begin
         $display("%0t: source_encoding readback expected %h got %h", $time,
                  {31'd0, enc}, csr_prdata);
         sb.failures++;
      end
   endtask

   function automatic void push_code_point(logic [20:0] cp, int len);
      case (len)
         1: run_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            run_bytes.push_back({3'b110, cp[10:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            run_bytes.push_back({4'b1110, cp[15:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            run_bytes.push_back({5'b11110, cp[20:18]});
            run_bytes.push_back({2'b10, cp[17:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // one random run: mostly well-formed sequences, some broken ones and noise
   function automatic void build_run();
      int unsigned lo[5] = '{0, 'h0, 'h80, 'h800, 'h10000};
      int unsigned hi[5] = '{0, 'h7F, 'h7FF, 'hFFFF, 'h10FFFF};
      int unsigned kind;
      int unsigned len;
      int unsigned pick;
      int unsigned r;
      logic [20:0] cp;
      run_bytes.delete();
      kind = $urandom_range(0, 15);
      len  = (kind <= 8) ? $urandom_range(1, 4) : $urandom_range(2, 4);
      pick = $urandom_range(0, 7);
      cp   = 21'((pick == 0) ? lo[len] :
                 (pick == 1) ? hi[len] : $urandom_range(lo[len], hi[len]));
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
      case (kind)
         9: push_code_point(21'($urandom_range(0, lo[len] - 1)), int'(len));  // overlong
         10: push_code_point(21'($urandom_range('hD800, 'hDFFF)), 3);         // surrogate
         11: push_code_point(21'($urandom_range('h110000, 'h1FFFFF)), 4);     // above range
         12: begin
            // one continuation replaced by a non-continuation byte
            push_code_point(cp, int'(len));
            r = $urandom_range(0, 191);
            run_bytes[$urandom_range(1, len - 1)] = 8'((r < 128) ? r : r + 64);
         end
         13: begin
            // truncated sequence
            push_code_point(cp, int'(len));
            repeat ($urandom_range(1, len - 1)) void'(run_bytes.pop_back());
         end
         14, 15: repeat ($urandom_range(1, 3)) run_bytes.push_back(8'($urandom_range(0, 255)));
         default: push_code_point(cp, int'(len));
      endcase
   endfunction

   initial begin
      int  sent;
      int  quota;
      int  p;
      bit  paused;
      logic enc;
      sb = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: UTF-8 special cases, then Latin-1 extremes
      foreach (directed_utf8[k]) send_text_byte(directed_utf8[k][7:0], directed_utf8[k][8]);
      wait_output_drained();
      write_source_encoding(ENC_LATIN1);
      foreach (directed_latin[k]) send_text_byte(directed_latin[k][7:0], directed_latin[k][8]);

      // random phases; phase 2 runs without idling, phase 3 rewrites the same mode
      paused = 1'b0;
      for (p = 0; p < 6; p++) begin
         enc = (p == 1 || p == 4) ? ENC_LATIN1 : ENC_UTF8;
         wait_output_drained();
         write_source_encoding(enc);
         no_idle = (p == 2);
         quota   = (enc == ENC_LATIN1) ? 25 : 48;
         sent    = 0;
         while (sent < quota) begin
            if (enc == ENC_LATIN1) begin
               send_text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
               sent++;
            end else begin
               build_run();
               foreach (run_bytes[k]) begin
                  send_text_byte(run_bytes[k], $urandom_range(0, 19) == 0);
                  sent++;
               end
            end
            // hold the sender until the output has fully drained
            if (p == 0 && sent >= 30 && !paused) begin
               wait_output_drained();
               paused = 1'b1;
            end
         end
      end
      no_idle = 1'b0;

      wait_output_drained();
      if (sb.failures == 0 && sb.expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
